// File: hw/rtl/dblf_pkg.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter package
// Shared request and filter codes and the records passed between pipeline
// stages of the edge line filter.
// ----------------------------------------------------------------------------
package dblf_pkg;

    // Request type codes. Code 3 is handled like the two-pair chroma request.
    typedef enum logic [1:0] {
        REQ_LUMA   = 2'd0,
        REQ_CHROMA = 2'd1,
        REQ_PAIR   = 2'd2,
        REQ_ALT    = 2'd3
    } t_req;

    // Filter kind codes reported with every result.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_WEAK   = 2'd1,
        KIND_STRONG = 2'd2,
        KIND_CHROMA = 2'd3
    } t_kind;

    // One input line as captured at the input register.
    typedef struct packed {
        t_req       req_type;
        logic [5:0] qp;
        logic [7:0] p3;
        logic [7:0] p2;
        logic [7:0] p1;
        logic [7:0] p0;
        logic [7:0] q0;
        logic [7:0] q1;
        logic [7:0] q2;
        logic [7:0] q3;
        logic [7:0] sec_p0;
        logic [7:0] sec_q0;
    } t_line;

    // Decisions and raw filter sums handed from the decision stage to the
    // filter stage.
    typedef struct packed {
        logic               chroma;
        logic               pair;
        logic               filt;
        logic               strong_sel;
        logic [3:0]         tc;
        logic [2:0]         tcc;
        logic [7:0]         p1;
        logic [7:0]         p0;
        logic [7:0]         q0;
        logic [7:0]         q1;
        logic [7:0]         sp;
        logic [7:0]         sq;
        logic signed [12:0] wk_p;
        logic signed [12:0] wk_q;
        logic signed [14:0] st_p1;
        logic signed [14:0] st_p0;
        logic signed [14:0] st_q0;
        logic signed [14:0] st_q1;
        logic signed [9:0]  cd_a;
        logic signed [9:0]  cd_b;
    } t_dec;

    // One finished result.
    typedef struct packed {
        logic [7:0] out_p1;
        logic [7:0] out_p0;
        logic [7:0] out_q0;
        logic [7:0] out_q1;
        logic [7:0] out_sec_p0;
        logic [7:0] out_sec_q0;
        t_kind      filter_kind;
    } t_res;

endpackage

// File: hw/rtl/deblocking_edge_line_filter.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter
// Filters one line of pixels across a block edge, luma or chroma, in a
// three-stage pipeline that takes one line every clock cycle.
// ----------------------------------------------------------------------------
// A line is taken whenever i_start is high; o_busy is always low, so a new
// transaction may be started in every cycle. Each transaction gives exactly
// one result, registered in turn by the input register, the decision stage
// (thresholds, grading and raw filter sums) and the filter stage (rounding,
// clipping and selection). The result stands on the output ports for one
// cycle, marked by o_valid, and must be taken then, since the block has no
// way to hold it.
module deblocking_edge_line_filter
    import dblf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_qp,
    input  logic [7:0] i_p3,
    input  logic [7:0] i_p2,
    input  logic [7:0] i_p1,
    input  logic [7:0] i_p0,
    input  logic [7:0] i_q0,
    input  logic [7:0] i_q1,
    input  logic [7:0] i_q2,
    input  logic [7:0] i_q3,
    input  logic [7:0] i_sec_p0,
    input  logic [7:0] i_sec_q0,
    output logic       o_valid,
    output logic [7:0] o_out_p1,
    output logic [7:0] o_out_p0,
    output logic [7:0] o_out_q0,
    output logic [7:0] o_out_q1,
    output logic [7:0] o_out_sec_p0,
    output logic [7:0] o_out_sec_q0,
    output logic [1:0] o_filter_kind
);

    logic  r_in_valid;
    t_line r_line;
    t_line n_line;
    logic  dec_valid;
    t_dec  dec;
    t_res  res;

    // The pipeline never stalls.
    assign o_busy = 1'b0;

    // Input register.
    always_comb begin
        n_line.req_type = t_req'(i_req_type);
        n_line.qp       = i_qp;
        n_line.p3       = i_p3;
        n_line.p2       = i_p2;
        n_line.p1       = i_p1;
        n_line.p0       = i_p0;
        n_line.q0       = i_q0;
        n_line.q1       = i_q1;
        n_line.q2       = i_q2;
        n_line.q3       = i_q3;
        n_line.sec_p0   = i_sec_p0;
        n_line.sec_q0   = i_sec_q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
        r_line <= n_line;
    end

    // Decision stage.
    dblf_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_line  (r_line),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    // Filter stage with the output register.
    dblf_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (o_valid),
        .o_res   (res)
    );

    assign o_out_p1      = res.out_p1;
    assign o_out_p0      = res.out_p0;
    assign o_out_q0      = res.out_q0;
    assign o_out_q1      = res.out_q1;
    assign o_out_sec_p0  = res.out_sec_p0;
    assign o_out_sec_q0  = res.out_sec_q0;
    assign o_filter_kind = res.filter_kind;

    // Every started transaction comes out as a result marked by o_valid.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_valid)
        else $error("started transaction did not produce a result on time");

    // A result never appears without a transaction started before it.
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 3)) |-> $past(i_start, 3))
        else $error("result strobe without a started transaction");

    // Luma results never carry second-plane pixels.
    a_luma_sec_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_filter_kind == KIND_STRONG || o_filter_kind == KIND_WEAK))
        |-> (o_out_sec_p0 == 8'd0 && o_out_sec_q0 == 8'd0))
        else $error("luma result with nonzero second-plane pixels");

    // Chroma smoothing leaves the outer pixels at zero.
    a_chroma_outer_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_filter_kind == KIND_CHROMA)
        |-> (o_out_p1 == 8'd0 && o_out_q1 == 8'd0))
        else $error("chroma result with nonzero outer pixels");

endmodule

// File: hw/rtl/dblf_decide.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter, decision stage
// Derives thresholds from qp, grades the edge step, checks flatness and
// forms the raw weak, strong and chroma filter sums.
// ----------------------------------------------------------------------------
module dblf_decide
    import dblf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_line i_line,
    output logic  o_valid,
    output t_dec  o_dec
);

    function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic        r_valid;
    t_dec        r_dec;
    t_dec        n_dec;

    logic [7:0]  d_pq;
    logic [3:0]  t1;
    logic [5:0]  t3;
    logic [12:0] qp_x43;
    logic [4:0]  qp_div3;
    logic [3:0]  tc;
    logic [5:0]  cqp;
    logic [3:0]  cq4;
    logic [3:0]  cthr;
    logic [2:0]  tcc;
    logic        chroma;
    logic        flat;
    logic        luma_filt;
    logic        chroma_filt;

    logic signed [12:0] w_p1, w_p0, w_q0, w_q1;
    logic signed [14:0] s_p3, s_p2, s_p1, s_p0, s_q0, s_q1, s_q2, s_q3;
    logic signed [9:0]  c_p0, c_q0, c_sp, c_sq;

    // Thresholds from qp. qp/3 is a multiply by 43/128, exact below 128.
    always_comb begin
        d_pq    = absd(i_line.p0, i_line.q0);
        t1      = (i_line.qp[5:2] < 4'd2) ? 4'd2 : i_line.qp[5:2];
        t3      = (i_line.qp < 6'd8) ? 6'd8 : ((i_line.qp > 6'd48) ? 6'd48 : i_line.qp);
        qp_x43  = 13'(i_line.qp) * 13'd43;
        qp_div3 = qp_x43[11:7];
        tc      = (qp_div3 < 5'd1) ? 4'd1 :
                  ((qp_div3 > 5'd10) ? 4'd10 : qp_div3[3:0]);
        cqp     = (i_line.qp == 6'd0) ? 6'd0 : (i_line.qp - 6'd1);
        cq4     = cqp[5:2];
        cthr    = (cq4 < 4'd2) ? 4'd2 : cq4;
        tcc     = (cq4 < 4'd1) ? 3'd1 : ((cq4 > 4'd6) ? 3'd6 : cq4[2:0]);
    end

    // Edge grading and flatness.
    always_comb begin
        chroma      = (i_line.req_type != REQ_LUMA);
        flat        = (absd(i_line.p2, i_line.p0) < {4'd0, tc}) &&
                      (absd(i_line.p3, i_line.p0) < {4'd0, tc}) &&
                      (absd(i_line.q2, i_line.q0) < {4'd0, tc}) &&
                      (absd(i_line.q3, i_line.q0) < {4'd0, tc});
        luma_filt   = (d_pq >= {4'd0, t1});
        chroma_filt = (d_pq >= {4'd0, cthr});
    end

    // Raw filter sums, all signed and wide enough for their full range.
    always_comb begin
        w_p1 = $signed({5'd0, i_line.p1});
        w_p0 = $signed({5'd0, i_line.p0});
        w_q0 = $signed({5'd0, i_line.q0});
        w_q1 = $signed({5'd0, i_line.q1});
        s_p3 = $signed({7'd0, i_line.p3});
        s_p2 = $signed({7'd0, i_line.p2});
        s_p1 = $signed({7'd0, i_line.p1});
        s_p0 = $signed({7'd0, i_line.p0});
        s_q0 = $signed({7'd0, i_line.q0});
        s_q1 = $signed({7'd0, i_line.q1});
        s_q2 = $signed({7'd0, i_line.q2});
        s_q3 = $signed({7'd0, i_line.q3});
        c_p0 = $signed({2'd0, i_line.p0});
        c_q0 = $signed({2'd0, i_line.q0});
        c_sp = $signed({2'd0, i_line.sec_p0});
        c_sq = $signed({2'd0, i_line.sec_q0});

        n_dec.chroma     = chroma;
        n_dec.pair       = chroma && (i_line.req_type != REQ_CHROMA);
        n_dec.filt       = chroma ? chroma_filt : luma_filt;
        n_dec.strong_sel = !chroma && luma_filt && (d_pq >= {2'd0, t3}) && flat;
        n_dec.tc     = tc;
        n_dec.tcc    = tcc;
        n_dec.p1     = i_line.p1;
        n_dec.p0     = i_line.p0;
        n_dec.q0     = i_line.q0;
        n_dec.q1     = i_line.q1;
        n_dec.sp     = i_line.sec_p0;
        n_dec.sq     = i_line.sec_q0;
        n_dec.wk_p   = (w_p0 <<< 2) + (w_q0 <<< 2) - w_p1 - w_q1 + 13'sd4;
        n_dec.wk_q   = (w_q0 <<< 2) + (w_p0 <<< 2) - w_q1 - w_p1 + 13'sd4;
        n_dec.st_p1  = s_p3 - s_p2 * 15'sd5 + s_p1 * 15'sd20 + s_p0 * 15'sd20
                       - s_q0 * 15'sd5 + 15'sd16;
        n_dec.st_p0  = s_p2 - s_p1 * 15'sd5 + s_p0 * 15'sd20 + s_q0 * 15'sd20
                       - s_q1 * 15'sd5 + 15'sd16;
        n_dec.st_q0  = s_p0 - s_q0 * 15'sd5 + s_q1 * 15'sd20 + s_q2 * 15'sd20
                       - s_q3 * 15'sd5 + 15'sd16;
        n_dec.st_q1  = s_p1 - s_q0 * 15'sd5 + s_q1 * 15'sd20 + s_q2 * 15'sd20
                       - s_q3 * 15'sd5 + 15'sd16;
        n_dec.cd_a   = c_q0 - c_p0 + 10'sd1;
        n_dec.cd_b   = c_sq - c_sp + 10'sd1;
    end

    // Stage register. Only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// File: hw/rtl/dblf_filter.sv
// ----------------------------------------------------------------------------
// Deblocking edge line filter, filter stage
// Rounds the raw sums, applies the clip limits, adds the corrections and
// selects the result pixels and filter kind into the output register.
// ----------------------------------------------------------------------------
module dblf_filter
    import dblf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_dec i_dec,
    output logic o_valid,
    output t_res o_res
);

    // Limit a correction to the range -lim..lim.
    function automatic logic signed [12:0] clip_sym(input logic signed [12:0] v,
                                                    input logic [3:0] lim);
        logic signed [12:0] lv;
        lv = $signed({9'd0, lim});
        return (v < -lv) ? -lv : ((v > lv) ? lv : v);
    endfunction

    // Clamp a signed value to the 8-bit pixel range.
    function automatic logic [7:0] clip255(input logic signed [14:0] v);
        return (v < 15'sd0) ? 8'd0 : ((v > 15'sd255) ? 8'd255 : v[7:0]);
    endfunction

    logic        r_valid;
    t_res        r_res;
    t_res        n_res;

    logic signed [12:0] wd_p, wd_q, cd_a, cd_b;
    logic signed [12:0] sum_wp, sum_wq, sum_cp, sum_cq, sum_sp, sum_sq;
    logic [7:0]         w_p0, w_q0, c_p0, c_q0, c_sp, c_sq;
    logic [7:0]         s_p1, s_p0, s_q0, s_q1;

    // Weak luma and chroma corrections, and the rounded strong luma pixels.
    always_comb begin
        wd_p   = clip_sym(i_dec.wk_p >>> 3, i_dec.tc);
        wd_q   = clip_sym(i_dec.wk_q >>> 3, i_dec.tc);
        cd_a   = clip_sym($signed({{3{i_dec.cd_a[9]}}, i_dec.cd_a}) >>> 1,
                          {1'b0, i_dec.tcc});
        cd_b   = clip_sym($signed({{3{i_dec.cd_b[9]}}, i_dec.cd_b}) >>> 1,
                          {1'b0, i_dec.tcc});
        sum_wp = $signed({5'd0, i_dec.p0}) + wd_p;
        sum_wq = $signed({5'd0, i_dec.q0}) + wd_q;
        sum_cp = $signed({5'd0, i_dec.p0}) + cd_a;
        sum_cq = $signed({5'd0, i_dec.q0}) - cd_a;
        sum_sp = $signed({5'd0, i_dec.sp}) + cd_b;
        sum_sq = $signed({5'd0, i_dec.sq}) - cd_b;
        w_p0   = clip255({{2{sum_wp[12]}}, sum_wp});
        w_q0   = clip255({{2{sum_wq[12]}}, sum_wq});
        c_p0   = clip255({{2{sum_cp[12]}}, sum_cp});
        c_q0   = clip255({{2{sum_cq[12]}}, sum_cq});
        c_sp   = clip255({{2{sum_sp[12]}}, sum_sp});
        c_sq   = clip255({{2{sum_sq[12]}}, sum_sq});
        s_p1   = clip255(i_dec.st_p1 >>> 5);
        s_p0   = clip255(i_dec.st_p0 >>> 5);
        s_q0   = clip255(i_dec.st_q0 >>> 5);
        s_q1   = clip255(i_dec.st_q1 >>> 5);
    end

    // Result selection by request class and decision.
    always_comb begin
        if (i_dec.chroma) begin
            n_res.out_p1      = 8'd0;
            n_res.out_q1      = 8'd0;
            n_res.out_p0      = i_dec.filt ? c_p0 : i_dec.p0;
            n_res.out_q0      = i_dec.filt ? c_q0 : i_dec.q0;
            n_res.out_sec_p0  = !i_dec.pair ? 8'd0 : (i_dec.filt ? c_sp : i_dec.sp);
            n_res.out_sec_q0  = !i_dec.pair ? 8'd0 : (i_dec.filt ? c_sq : i_dec.sq);
            n_res.filter_kind = i_dec.filt ? KIND_CHROMA : KIND_NONE;
        end else if (i_dec.strong_sel) begin
            n_res.out_p1      = s_p1;
            n_res.out_p0      = s_p0;
            n_res.out_q0      = s_q0;
            n_res.out_q1      = s_q1;
            n_res.out_sec_p0  = 8'd0;
            n_res.out_sec_q0  = 8'd0;
            n_res.filter_kind = KIND_STRONG;
        end else begin
            n_res.out_p1      = i_dec.p1;
            n_res.out_q1      = i_dec.q1;
            n_res.out_p0      = i_dec.filt ? w_p0 : i_dec.p0;
            n_res.out_q0      = i_dec.filt ? w_q0 : i_dec.q0;
            n_res.out_sec_p0  = 8'd0;
            n_res.out_sec_q0  = 8'd0;
            n_res.filter_kind = i_dec.filt ? KIND_WEAK : KIND_NONE;
        end
    end

    // Output register. Only the strobe is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
